@@ rtl/cdfp_pkg.sv @@
package cdfp_pkg;

    typedef enum logic [1:0] {
        CMD_FORCE = 2'd0,
        CMD_LOGIC = 2'd1,
        CMD_PROT  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_FIN
    } t_op;

    // register indexes
    localparam logic [2:0] REG_COIL_RES = 3'd0;
    localparam logic [2:0] REG_MAX_VOUT = 3'd1;
    localparam logic [2:0] REG_MIN_VSUP = 3'd2;
    localparam logic [2:0] REG_MAX_VSUP = 3'd3;
    localparam logic [2:0] REG_MAX_IOUT = 3'd4;
    localparam logic [2:0] REG_MAX_POUT = 3'd5;
    localparam logic [2:0] REG_MIN_ZOUT = 3'd6;
    localparam logic [2:0] REG_MAX_ZOUT = 3'd7;
    localparam int         NUM_REGS     = 8;

    // warning / counter positions
    localparam int W_UVLO  = 0;
    localparam int W_OVLO  = 1;
    localparam int W_OCP   = 2;
    localparam int W_OPP   = 3;
    localparam int W_SHORT = 4;
    localparam int W_LOSS  = 5;
    localparam int NUM_WARN = 6;

    // fault flag positions
    localparam int F_SUPPLY = 0;
    localparam int F_OUTPUT = 1;
    localparam int F_LOSS   = 2;

    localparam logic [15:0] MILLI     = 16'd1000;
    localparam logic [15:0] PERCENT   = 16'd100;
    localparam logic [15:0] SAT_MAX   = 16'hFFFF;
    localparam logic [7:0]  CNT_MAX   = 8'd255;
    localparam logic [7:0]  FORCE_MAX = 8'd100;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  force_req;
        logic [15:0] supply_mv;
        logic [15:0] coil_current_ma;
        logic [15:0] coil_voltage_mv;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_permille;
        logic        drive_off;
        logic        supply_fault;
        logic        output_fault;
        logic        load_loss_fault;
        logic [7:0]  output_fault_events;
        logic [15:0] impedance_mohm;
        logic [15:0] power_mw;
        logic [5:0]  warnings;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg;

    function automatic logic [15:0] sat16(input logic [47:0] v);
        sat16 = (|v[47:16]) ? SAT_MAX : v[15:0];
    endfunction

endpackage

@@ rtl/cdfp_chan.sv @@
interface cdfp_chan #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/coil_driver_fault_protector_top.sv @@
// Coil driver controller with fault protection. Each input beat carries a
// command: set force (derives the target coil voltage), logic tick (applies
// the target, starts the lag deadtime on change, drives zero under a supply
// or output fault, returns supply-compensated PWM permille) or protection
// tick (impedance, power, six threshold warnings, saturating fault counters,
// supply / output / load-loss faults with output cooldown and onset count).
// Every beat in gives exactly one result beat. All arithmetic runs on one
// bit-serial shift-add multiplier (one multiplier bit per cycle) and one
// restoring divider (one quotient bit per cycle); beats are handled one at
// a time. A protection tick runs two multiplies and two divides. A new beat
// is accepted while the previous result waits in the output register.
// Config writes are always accepted and must only be issued while the
// block is idle.
module coil_driver_fault_protector_top #(
    parameter int LOCK_CURRENT_MA    = 1000,
    parameter int LAG_TICKS          = 10,
    parameter int COOLDOWN_TICKS     = 1000,
    parameter int SUPPLY_FAULT_DELAY = 50,
    parameter int OUTPUT_FAULT_DELAY = 10,
    parameter int LOSS_FAULT_DELAY   = 50
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cdfp_chan.sink   i_in,
    cdfp_chan.source o_res,
    cdfp_chan.sink   i_cfg
);

    localparam logic [15:0] LOCK_MA   = 16'(LOCK_CURRENT_MA);
    localparam logic [7:0]  LAG       = 8'(LAG_TICKS);
    localparam logic [15:0] COOLDOWN  = 16'(COOLDOWN_TICKS);
    localparam logic [7:0]  SUP_DELAY = 8'(SUPPLY_FAULT_DELAY);
    localparam logic [7:0]  OUT_DELAY = 8'(OUTPUT_FAULT_DELAY);
    localparam logic [7:0]  LOS_DELAY = 8'(LOSS_FAULT_DELAY);

    // ---------------- registers ----------------
    cdfp_pkg::t_state    r_state, n_state;
    logic [15:0]         r_regs [cdfp_pkg::NUM_REGS];
    cdfp_pkg::t_in_item  r_item;
    logic [2:0]          r_step;
    logic [4:0]          r_cnt;

    // serial arithmetic
    logic [47:0]         r_ma;    // multiplicand, shifts left
    logic [15:0]         r_b;     // multiplier bits / divisor
    logic [47:0]         r_acc;
    logic [31:0]         r_quo;   // dividend in, quotient out
    logic [15:0]         r_rem;
    logic [47:0]         r_val;   // last unit result
    logic [15:0]         r_z;

    // controller state
    logic [15:0]         r_target;
    logic [15:0]         r_applied;
    logic [7:0]          r_dead;
    logic                r_zoff;
    logic [15:0]         r_cool;
    logic [7:0]          r_fcnt [cdfp_pkg::NUM_WARN];
    logic [2:0]          r_flags;
    logic [7:0]          r_events;
    logic                r_doff;

    cdfp_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic in_acc, fin_go;
    assign i_in.ready  = (r_state == cdfp_pkg::S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign fin_go      = (r_state == cdfp_pkg::S_FIN) && (!r_out_valid || o_res.ready);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // ---------------- dispatch: next operation of the beat ----------------
    cdfp_pkg::t_op d_op;
    logic [47:0]   d_a;
    logic [15:0]   d_b;
    logic          f_r0nz, f_mid;

    assign f_r0nz = (r_regs[cdfp_pkg::REG_COIL_RES] != 16'd0);
    assign f_mid  = (r_item.force_req != 8'd0) && (r_item.force_req <= cdfp_pkg::FORCE_MAX);

    always_comb begin
        d_op = cdfp_pkg::OP_FIN;
        d_a  = r_val;
        d_b  = cdfp_pkg::PERCENT;
        case (r_item.cmd)
            cdfp_pkg::CMD_FORCE: begin
                if (f_r0nz && r_item.force_req != 8'd0) begin
                    // full = R * I_lock; share = (full / 100) * force
                    case (r_step)
                        3'd0: begin
                            d_op = cdfp_pkg::OP_MUL;
                            d_a  = {32'd0, r_regs[cdfp_pkg::REG_COIL_RES]};
                            d_b  = LOCK_MA;
                        end
                        3'd1: d_op = f_mid ? cdfp_pkg::OP_DIV : cdfp_pkg::OP_FIN;
                        3'd2: begin
                            d_op = cdfp_pkg::OP_MUL;
                            d_b  = {8'd0, r_item.force_req};
                        end
                        default: d_op = cdfp_pkg::OP_FIN;
                    endcase
                end else if (!f_r0nz && f_mid) begin
                    // (Vmax * force) / 100
                    case (r_step)
                        3'd0: begin
                            d_op = cdfp_pkg::OP_MUL;
                            d_a  = {32'd0, r_regs[cdfp_pkg::REG_MAX_VOUT]};
                            d_b  = {8'd0, r_item.force_req};
                        end
                        3'd1: d_op = cdfp_pkg::OP_DIV;
                        default: d_op = cdfp_pkg::OP_FIN;
                    endcase
                end
            end
            cdfp_pkg::CMD_LOGIC: begin
                if (r_item.supply_mv != 16'd0 && r_applied != 16'd0) begin
                    case (r_step)
                        3'd0: begin
                            d_op = cdfp_pkg::OP_MUL;
                            d_a  = {32'd0, r_applied};
                            d_b  = cdfp_pkg::MILLI;
                        end
                        3'd1: begin
                            d_op = cdfp_pkg::OP_DIV;
                            d_b  = r_item.supply_mv;
                        end
                        default: d_op = cdfp_pkg::OP_FIN;
                    endcase
                end
            end
            cdfp_pkg::CMD_PROT: begin
                case (r_step)
                    3'd0: begin
                        d_op = cdfp_pkg::OP_MUL;
                        d_a  = {32'd0, r_item.coil_voltage_mv};
                        d_b  = cdfp_pkg::MILLI;
                    end
                    3'd1: begin
                        d_op = cdfp_pkg::OP_DIV;
                        d_b  = r_item.coil_current_ma;
                    end
                    3'd2: begin
                        d_op = cdfp_pkg::OP_MUL;
                        d_a  = {32'd0, r_item.coil_voltage_mv};
                        d_b  = r_item.coil_current_ma;
                    end
                    3'd3: begin
                        d_op = cdfp_pkg::OP_DIV;
                        d_b  = cdfp_pkg::MILLI;
                    end
                    default: d_op = cdfp_pkg::OP_FIN;
                endcase
            end
            default: d_op = cdfp_pkg::OP_FIN;
        endcase
    end

    // ---------------- serial unit step ----------------
    logic [47:0] mul_sum;
    logic [16:0] div_t;
    logic        div_ge;
    logic [16:0] div_r;
    logic [31:0] div_q;

    assign mul_sum = r_acc + (r_b[0] ? r_ma : 48'd0);
    assign div_t   = {r_rem, r_quo[31]};
    assign div_ge  = (div_t >= {1'b0, r_b});
    assign div_r   = div_ge ? (div_t - {1'b0, r_b}) : div_t;
    assign div_q   = {r_quo[30:0], div_ge};

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdfp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cdfp_pkg::S_IDLE: if (in_acc) n_state = cdfp_pkg::S_DISP;
            cdfp_pkg::S_DISP: begin
                case (d_op)
                    cdfp_pkg::OP_MUL: n_state = cdfp_pkg::S_MUL;
                    cdfp_pkg::OP_DIV: n_state = cdfp_pkg::S_DIV;
                    default:          n_state = cdfp_pkg::S_FIN;
                endcase
            end
            cdfp_pkg::S_MUL: if (r_cnt == 5'd15) n_state = cdfp_pkg::S_DISP;
            cdfp_pkg::S_DIV: if (r_cnt == 5'd31) n_state = cdfp_pkg::S_DISP;
            cdfp_pkg::S_FIN: if (fin_go) n_state = cdfp_pkg::S_IDLE;
            default:         n_state = cdfp_pkg::S_IDLE;
        endcase
    end

    // datapath sequencing, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.data;
            r_step <= 3'd0;
        end
        case (r_state)
            cdfp_pkg::S_DISP: begin
                r_ma  <= d_a;
                r_b   <= d_b;
                r_acc <= 48'd0;
                r_quo <= r_val[31:0];
                r_rem <= 16'd0;
                r_cnt <= 5'd0;
                // impedance quotient is ready when the power product starts
                if (r_item.cmd == cdfp_pkg::CMD_PROT && r_step == 3'd2) begin
                    r_z <= cdfp_pkg::sat16(r_val);
                end
            end
            cdfp_pkg::S_MUL: begin
                r_acc <= mul_sum;
                r_ma  <= {r_ma[46:0], 1'b0};
                r_b   <= {1'b0, r_b[15:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_val  <= mul_sum;
                    r_step <= r_step + 3'd1;
                end
            end
            cdfp_pkg::S_DIV: begin
                r_rem <= div_r[15:0];
                r_quo <= div_q;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_val  <= {16'd0, div_q};
                    r_step <= r_step + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- finish: results and state updates ----------------
    logic [15:0] f_sat, f_z, f_target, f_pwm;
    logic [5:0]  f_warn, f_up;
    logic        f_zok, f_otrip;
    logic [7:0]  f_cnt [cdfp_pkg::NUM_WARN];
    logic [2:0]  f_flags;
    logic [15:0] f_cool;
    logic [7:0]  f_events;

    assign f_sat = cdfp_pkg::sat16(r_val);
    assign f_z   = (r_item.coil_current_ma == 16'd0) ? cdfp_pkg::SAT_MAX : r_z;
    assign f_zok = (r_dead == 8'd0) && !r_zoff;

    always_comb begin
        if (r_item.force_req == 8'd0)
            f_target = 16'd0;
        else if (!f_r0nz && !f_mid)
            f_target = r_regs[cdfp_pkg::REG_MAX_VOUT];
        else
            f_target = f_sat;

        f_pwm = (r_item.supply_mv != 16'd0 && r_applied != 16'd0) ? f_sat : 16'd0;

        f_warn = '0;
        f_warn[cdfp_pkg::W_UVLO]  = (r_regs[cdfp_pkg::REG_MIN_VSUP] != 16'd0)
                                 && (r_item.supply_mv < r_regs[cdfp_pkg::REG_MIN_VSUP]);
        f_warn[cdfp_pkg::W_OVLO]  = (r_regs[cdfp_pkg::REG_MAX_VSUP] != 16'd0)
                                 && (r_item.supply_mv > r_regs[cdfp_pkg::REG_MAX_VSUP]);
        f_warn[cdfp_pkg::W_OCP]   = (r_regs[cdfp_pkg::REG_MAX_IOUT] != 16'd0)
                                 && (r_item.coil_current_ma > r_regs[cdfp_pkg::REG_MAX_IOUT]);
        f_warn[cdfp_pkg::W_OPP]   = (r_regs[cdfp_pkg::REG_MAX_POUT] != 16'd0)
                                 && (f_sat > r_regs[cdfp_pkg::REG_MAX_POUT]);
        f_warn[cdfp_pkg::W_SHORT] = (r_regs[cdfp_pkg::REG_MIN_ZOUT] != 16'd0)
                                 && (f_z < r_regs[cdfp_pkg::REG_MIN_ZOUT]);
        f_warn[cdfp_pkg::W_LOSS]  = (r_regs[cdfp_pkg::REG_MAX_ZOUT] != 16'd0)
                                 && (f_z > r_regs[cdfp_pkg::REG_MAX_ZOUT]);

        // short and loss only count once the load has settled
        f_up = f_warn;
        f_up[cdfp_pkg::W_SHORT] = f_warn[cdfp_pkg::W_SHORT] && f_zok;
        f_up[cdfp_pkg::W_LOSS]  = f_warn[cdfp_pkg::W_LOSS] && f_zok;

        for (int i = 0; i < cdfp_pkg::NUM_WARN; i++) begin
            if (f_up[i])
                f_cnt[i] = (r_fcnt[i] == cdfp_pkg::CNT_MAX) ? r_fcnt[i] : r_fcnt[i] + 8'd1;
            else
                f_cnt[i] = (r_fcnt[i] == 8'd0) ? r_fcnt[i] : r_fcnt[i] - 8'd1;
        end

        f_otrip = (f_cnt[cdfp_pkg::W_OCP] > OUT_DELAY) || (f_cnt[cdfp_pkg::W_OPP] > OUT_DELAY)
               || (f_cnt[cdfp_pkg::W_SHORT] > OUT_DELAY);

        f_flags  = r_flags;
        f_cool   = r_cool;
        f_events = r_events;
        f_flags[cdfp_pkg::F_SUPPLY] = (f_cnt[cdfp_pkg::W_UVLO] > SUP_DELAY)
                                   || (f_cnt[cdfp_pkg::W_OVLO] > SUP_DELAY);
        if (f_otrip) begin
            if (!r_flags[cdfp_pkg::F_OUTPUT]) f_events = r_events + 8'd1;
            f_flags[cdfp_pkg::F_OUTPUT] = 1'b1;
            f_cool = COOLDOWN;
        end else if (r_cool != 16'd0) begin
            f_cool = r_cool - 16'd1;
        end else begin
            f_flags[cdfp_pkg::F_OUTPUT] = 1'b0;
        end
        f_flags[cdfp_pkg::F_LOSS] = (f_cnt[cdfp_pkg::W_LOSS] > LOS_DELAY);
    end

    // applied voltage after a logic tick
    logic [15:0] a_applied;
    always_comb begin
        if (r_flags[cdfp_pkg::F_SUPPLY] || r_flags[cdfp_pkg::F_OUTPUT])
            a_applied = 16'd0;
        else
            a_applied = r_target;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cdfp_pkg::NUM_REGS; i++) r_regs[i] <= 16'd0;
            for (int i = 0; i < cdfp_pkg::NUM_WARN; i++) r_fcnt[i] <= 8'd0;
            r_target    <= 16'd0;
            r_applied   <= 16'd0;
            r_dead      <= 8'd0;
            r_zoff      <= 1'b0;
            r_cool      <= 16'd0;
            r_flags     <= 3'd0;
            r_events    <= 8'd0;
            r_doff      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_regs[i_cfg.data.index] <= i_cfg.data.value;
            end

            if (in_acc) begin
                r_doff <= 1'b0;
                if (i_in.data.cmd == cdfp_pkg::CMD_LOGIC) begin
                    r_applied <= a_applied;
                    r_zoff    <= (a_applied == 16'd0);
                    if (r_flags[cdfp_pkg::F_SUPPLY] || r_flags[cdfp_pkg::F_OUTPUT]) begin
                        r_doff <= 1'b1;
                    end else if (r_applied != r_target) begin
                        r_dead <= LAG;
                    end
                end
            end

            if (o_res.ready) r_out_valid <= 1'b0;

            if (fin_go) begin
                r_out_valid <= 1'b1;
                case (r_item.cmd)
                    cdfp_pkg::CMD_FORCE: r_target <= f_target;
                    cdfp_pkg::CMD_PROT: begin
                        for (int i = 0; i < cdfp_pkg::NUM_WARN; i++) r_fcnt[i] <= f_cnt[i];
                        r_flags  <= f_flags;
                        r_cool   <= f_cool;
                        r_events <= f_events;
                        if (r_dead != 8'd0) r_dead <= r_dead - 8'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out <= '0;
            case (r_item.cmd)
                cdfp_pkg::CMD_LOGIC: begin
                    r_out.pwm_permille <= f_pwm;
                    r_out.drive_off    <= r_doff;
                end
                cdfp_pkg::CMD_PROT: begin
                    r_out.impedance_mohm <= f_z;
                    r_out.power_mw       <= f_sat;
                    r_out.warnings       <= f_warn;
                end
                default: ;
            endcase
            if (r_item.cmd == cdfp_pkg::CMD_PROT) begin
                r_out.supply_fault        <= f_flags[cdfp_pkg::F_SUPPLY];
                r_out.output_fault        <= f_flags[cdfp_pkg::F_OUTPUT];
                r_out.load_loss_fault     <= f_flags[cdfp_pkg::F_LOSS];
                r_out.output_fault_events <= f_events;
            end else begin
                r_out.supply_fault        <= r_flags[cdfp_pkg::F_SUPPLY];
                r_out.output_fault        <= r_flags[cdfp_pkg::F_OUTPUT];
                r_out.load_loss_fault     <= r_flags[cdfp_pkg::F_LOSS];
                r_out.output_fault_events <= r_events;
            end
        end
    end

    // ---------------- assertions ----------------
    a_cool_has_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cool != 16'd0 |-> r_flags[cdfp_pkg::F_OUTPUT])
        else $error("cooldown running without output fault");

    a_event_on_onset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_events) |-> r_flags[cdfp_pkg::F_OUTPUT] && !$past(r_flags[cdfp_pkg::F_OUTPUT]))
        else $error("fault event counted without onset");

    a_doff_no_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_off |-> r_out.pwm_permille == 16'd0)
        else $error("pwm nonzero with drive off");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.pwm_permille != 16'd0 |->
            r_out.impedance_mohm == 16'd0 && r_out.power_mw == 16'd0)
        else $error("logic and protection results mixed");

endmodule
